### design/rgbmd_pkg.sv
// ----------------------------------------------------------------------------
// rgbmd_pkg: shared types and constants for the RGB dilation core
// Word formats of both streams, register indexes, reset values.
// ----------------------------------------------------------------------------
package rgbmd_pkg;

	localparam int DEFAULT_KERNEL_SIZE = 3;
	localparam int DEFAULT_MAX_WIDTH   = 1920;
	localparam int DEFAULT_MAX_HEIGHT  = 1080;

	localparam int PIX_W       = 24;
	localparam int CH_W        = 8;
	localparam int GEOM_W      = 11;
	localparam int QUEUE_DEPTH = 4;
	localparam int REG_IDX_W   = 2;

	localparam logic [REG_IDX_W-1:0] REG_MASK   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [GEOM_W-1:0] RESET_WIDTH  = 11'd1920;
	localparam logic [GEOM_W-1:0] RESET_HEIGHT = 11'd1080;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pixel_in;
	} in_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             row_end;
		logic             frame_end;
	} out_word_t;

endpackage

### design/rgbmd_front.sv
// ----------------------------------------------------------------------------
// rgbmd_front: input classifier
// Tracks raster position, drops words that do not fit the frame phase and
// tags each kept word with its window-row validity and emit flags.
// ----------------------------------------------------------------------------
module rgbmd_front import rgbmd_pkg::*; #(
	parameter int KERNEL_SIZE = DEFAULT_KERNEL_SIZE,
	parameter int MAX_WIDTH   = DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEFAULT_MAX_HEIGHT,
	parameter type entry_t    = logic
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [GEOM_W-1:0] image_width,
	input  logic [GEOM_W-1:0] image_height,
	input  logic              restart,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  in_word_t          pix_data,
	output logic              q_valid,
	input  logic              q_ready,
	output entry_t            q_data
);

	localparam int HALF = KERNEL_SIZE / 2;
	localparam int CW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(MAX_HEIGHT + 2 * KERNEL_SIZE);
	localparam int SW   = $clog2(KERNEL_SIZE);
	localparam int GWW  = (CW > GEOM_W) ? CW : GEOM_W;
	localparam int GWH  = (RW > GEOM_W) ? RW : GEOM_W;

	logic [GWW-1:0] wide_w;
	logic [GWH-1:0] wide_h;
	logic [CW-1:0]  w_c;
	logic [RW-1:0]  h_c;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [SW-1:0]  base_q;
	logic [CW-1:0]  col_nxt;
	logic [RW-1:0]  row_nxt;
	logic [RW-1:0]  row_lim;
	logic           col_wrap;
	logic           flushing;
	logic           keep;
	logic           push;

	always_comb begin
		wide_w = GWW'(image_width);
		wide_h = GWH'(image_height);
		if (wide_w < GWW'(2)) begin
			w_c = CW'(2);
		end else if (wide_w > GWW'(MAX_WIDTH)) begin
			w_c = CW'(MAX_WIDTH);
		end else begin
			w_c = CW'(wide_w);
		end
		if (wide_h < GWH'(2)) begin
			h_c = RW'(2);
		end else if (wide_h > GWH'(MAX_HEIGHT)) begin
			h_c = RW'(MAX_HEIGHT);
		end else begin
			h_c = RW'(wide_h);
		end
	end

	assign col_nxt  = col_q + CW'(1);
	assign row_nxt  = row_q + RW'(1);
	assign row_lim  = h_c + RW'(HALF);
	assign col_wrap = (col_nxt == w_c);
	assign flushing = (row_q >= h_c);
	assign keep     = (pix_data.kind == KIND_FLUSH) == flushing;

	assign pix_ready = q_ready;
	assign q_valid   = pix_valid && keep;
	assign push      = q_valid && q_ready;

	always_comb begin
		q_data           = '0;
		q_data.pix       = pix_data.pixel_in;
		q_data.col       = col_q;
		q_data.base      = base_q;
		q_data.first     = (col_q == '0);
		q_data.we        = !flushing;
		q_data.emit_main = (row_q >= RW'(HALF)) && (col_q >= CW'(HALF));
		q_data.tail      = (row_q >= RW'(HALF)) && col_wrap;
		q_data.orow_last = (row_nxt == row_lim);
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			q_data.row_ok[i] = (row_q + RW'(i) >= RW'(2 * HALF)) &&
				(row_q + RW'(i) < h_c + RW'(2 * HALF));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (col_wrap) begin
				col_q  <= '0;
				row_q  <= (row_nxt == row_lim) ? '0 : row_nxt;
				base_q <= (base_q == SW'(KERNEL_SIZE - 1)) ? '0 : base_q + SW'(1);
			end else begin
				col_q <= col_nxt;
			end
		end
	end

endmodule

### design/rgbmd_queue.sv
// ----------------------------------------------------------------------------
// rgbmd_queue: short FIFO between classifier and window engine
// ----------------------------------------------------------------------------
module rgbmd_queue import rgbmd_pkg::*; #(
	parameter int DEPTH    = QUEUE_DEPTH,
	parameter type entry_t = logic
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  entry_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output entry_t out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != CNT_W'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

### design/rgbmd_back.sv
// ----------------------------------------------------------------------------
// rgbmd_back: line store, sliding window and masked per-channel maximum
// Banked line memory (one bank per kernel row), window shift with tail
// steps at row end, then a two-level registered maximum tree.
// ----------------------------------------------------------------------------
module rgbmd_back import rgbmd_pkg::*; #(
	parameter int KERNEL_SIZE = DEFAULT_KERNEL_SIZE,
	parameter int MAX_WIDTH   = DEFAULT_MAX_WIDTH,
	parameter type entry_t    = logic
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [KERNEL_SIZE*KERNEL_SIZE-1:0]   kernel_mask,
	input  logic                                 q_valid,
	output logic                                 q_ready,
	input  entry_t                               q_data,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output out_word_t                            res_data
);

	localparam int HALF = KERNEL_SIZE / 2;
	localparam int CW   = $clog2(MAX_WIDTH + 1);
	localparam int SW   = $clog2(KERNEL_SIZE);
	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int PW   = $clog2(HALF + 1);
	localparam int NCH  = PIX_W / CH_W;

	logic [PIX_W-1:0] mem [KERNEL_SIZE][MAX_WIDTH];
	logic [PIX_W-1:0] rd_s1 [KERNEL_SIZE];
	logic [PIX_W-1:0] win_q [KERNEL_SIZE][KERNEL_SIZE];
	logic [PIX_W-1:0] win_nxt [KERNEL_SIZE][KERNEL_SIZE];
	logic [PIX_W-1:0] col_v [KERNEL_SIZE];
	logic [CH_W-1:0]  rowmax [KERNEL_SIZE][NCH];
	logic [CH_W-1:0]  rowmax_s2 [KERNEL_SIZE][NCH];
	logic [PIX_W-1:0] pix_max;

	entry_t         ent_s1;
	logic           vld_s1;
	logic [PW-1:0]  phase_s1;
	logic           vld_s2;
	logic           row_end_s2;
	logic           frame_end_s2;
	logic           res_valid_q;
	out_word_t      res_q;

	logic [SW-1:0]  wslot;
	logic [AW-1:0]  addr;
	logic           pop;
	logic           emit_now;
	logic           last_phase;
	logic           step_go;
	logic           done_s1;
	logic           out_free;
	logic           s2_free;
	logic           clear_win;
	logic           tail_row_end;

	assign wslot = (q_data.base == '0) ? SW'(KERNEL_SIZE - 1) : q_data.base - SW'(1);
	assign addr  = q_data.col[AW-1:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int p = 0; p < KERNEL_SIZE; p++) begin
				if (q_data.we && wslot == SW'(p)) begin
					mem[p][addr] <= q_data.pix;
				end
				rd_s1[p] <= mem[p][addr];
			end
		end
	end

	always_comb begin
		logic [SW:0]      slot_sum;
		logic [PIX_W-1:0] col_raw;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			slot_sum = (SW+1)'(ent_s1.base) + (SW+1)'(i);
			if (slot_sum >= (SW+1)'(KERNEL_SIZE)) begin
				slot_sum = slot_sum - (SW+1)'(KERNEL_SIZE);
			end
			if (i == KERNEL_SIZE - 1) begin
				col_raw = ent_s1.pix;
			end else begin
				col_raw = rd_s1[slot_sum[SW-1:0]];
			end
			col_v[i] = (phase_s1 == '0 && ent_s1.row_ok[i]) ? col_raw : '0;
		end
	end

	assign clear_win = (phase_s1 == '0) && ent_s1.first;

	always_comb begin
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
				win_nxt[i][j] = clear_win ? '0 : win_q[i][j+1];
			end
			win_nxt[i][KERNEL_SIZE-1] = col_v[i];
		end
	end

	always_comb begin
		logic [CH_W-1:0] best;
		logic [CH_W-1:0] v;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int ch = 0; ch < NCH; ch++) begin
				best = '0;
				for (int j = 0; j < KERNEL_SIZE; j++) begin
					v = win_nxt[i][j][ch*CH_W +: CH_W];
					if (kernel_mask[i*KERNEL_SIZE+j] && v > best) begin
						best = v;
					end
				end
				rowmax[i][ch] = best;
			end
		end
	end

	always_comb begin
		logic [CH_W-1:0] best;
		for (int ch = 0; ch < NCH; ch++) begin
			best = '0;
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				if (rowmax_s2[i][ch] > best) begin
					best = rowmax_s2[i][ch];
				end
			end
			pix_max[ch*CH_W +: CH_W] = best;
		end
	end

	// tail steps shift in empty columns past the right edge
	assign emit_now = (phase_s1 == '0) ? ent_s1.emit_main :
		((CW+1)'(ent_s1.col) + (CW+1)'(phase_s1) >= (CW+1)'(HALF));
	assign last_phase   = ent_s1.tail ? (phase_s1 == PW'(HALF)) : (phase_s1 == '0);
	assign tail_row_end = (phase_s1 == PW'(HALF));
	assign out_free     = !res_valid_q || res_ready;
	assign s2_free      = !vld_s2 || out_free;
	assign step_go      = vld_s1 && (!emit_now || s2_free);
	assign done_s1      = step_go && last_phase;
	assign q_ready      = !vld_s1 || done_s1;
	assign pop          = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1 <= q_data;
		end
		if (step_go) begin
			win_q <= win_nxt;
		end
		if (step_go && emit_now && s2_free) begin
			rowmax_s2    <= rowmax;
			row_end_s2   <= tail_row_end;
			frame_end_s2 <= tail_row_end && ent_s1.orow_last;
		end
		if (vld_s2 && out_free) begin
			res_q.pixel_out <= pix_max;
			res_q.row_end   <= row_end_s2;
			res_q.frame_end <= frame_end_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			phase_s1    <= '0;
			vld_s2      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_s1 <= 1'b1;
			end else if (done_s1) begin
				vld_s1 <= 1'b0;
			end
			if (step_go) begin
				phase_s1 <= done_s1 ? '0 : phase_s1 + PW'(1);
			end
			if (s2_free) begin
				vld_s2 <= step_go && emit_now;
			end
			if (out_free) begin
				res_valid_q <= vld_s2;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

### design/rgb_morphological_dilation_core.sv
// ----------------------------------------------------------------------------
// rgb_morphological_dilation_core: KxK masked RGB dilation over a raster
// Results pass the queue, window, row-maximum and output registers and
// trail the input by K/2 rows and K/2 columns.
// Throughput: one word per cycle unless res_ready stalls the output;
// a row's last word holds the window engine to shift out trailing columns.
// Reset: position counters and valid flags clear, registers take defaults;
// the line memory is not cleared (rows outside the image are masked).
// ----------------------------------------------------------------------------
module rgb_morphological_dilation_core import rgbmd_pkg::*; #(
	parameter int KERNEL_SIZE = DEFAULT_KERNEL_SIZE,
	parameter int MAX_WIDTH   = DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEFAULT_MAX_HEIGHT,
	localparam int TAPS       = KERNEL_SIZE * KERNEL_SIZE,
	localparam int DW         = (TAPS > 32) ? 64 : 32,
	localparam int STRIDE     = DW / 8,
	localparam int PAW        = $clog2(3 * STRIDE)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  in_word_t        pix_data,
	output logic            res_valid,
	input  logic            res_ready,
	output out_word_t       res_data,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [PAW-1:0]  paddr,
	input  logic [DW-1:0]   pwdata,
	output logic [DW-1:0]   prdata,
	output logic            pready
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(KERNEL_SIZE);

	typedef struct packed {
		logic [PIX_W-1:0]       pix;
		logic [CW-1:0]          col;
		logic [SW-1:0]          base;
		logic [KERNEL_SIZE-1:0] row_ok;
		logic                   first;
		logic                   we;
		logic                   emit_main;
		logic                   tail;
		logic                   orow_last;
	} entry_t;

	logic [TAPS-1:0]      mask_q;
	logic [GEOM_W-1:0]    width_q;
	logic [GEOM_W-1:0]    height_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic                 restart;

	logic   fq_valid;
	logic   fq_ready;
	entry_t fq_data;
	logic   qb_valid;
	logic   qb_ready;
	entry_t qb_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PAW-1 -: REG_IDX_W];
	assign wr_en   = psel && penable && pwrite && pready;
	assign restart = wr_en && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '1;
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MASK: begin
					mask_q <= pwdata[TAPS-1:0];
				end
				REG_WIDTH: begin
					width_q <= pwdata[GEOM_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= pwdata[GEOM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MASK:   prdata = DW'(mask_q);
			REG_WIDTH:  prdata = DW'(width_q);
			REG_HEIGHT: prdata = DW'(height_q);
			default:    prdata = '0;
		endcase
	end

	rgbmd_front #(
		.KERNEL_SIZE (KERNEL_SIZE),
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.entry_t     (entry_t)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (width_q),
		.image_height (height_q),
		.restart      (restart),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.pix_data     (pix_data),
		.q_valid      (fq_valid),
		.q_ready      (fq_ready),
		.q_data       (fq_data)
	);

	rgbmd_queue #(
		.DEPTH   (QUEUE_DEPTH),
		.entry_t (entry_t)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_data)
	);

	rgbmd_back #(
		.KERNEL_SIZE (KERNEL_SIZE),
		.MAX_WIDTH   (MAX_WIDTH),
		.entry_t     (entry_t)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.kernel_mask (mask_q),
		.q_valid     (qb_valid),
		.q_ready     (qb_ready),
		.q_data      (qb_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_data    (res_data)
	);

endmodule

### design/rgbmd_checker.sv
// ----------------------------------------------------------------------------
// rgbmd_checker: port-level assertions for the dilation core
// ----------------------------------------------------------------------------
module rgbmd_checker import rgbmd_pkg::*; #(
	parameter int KERNEL_SIZE = DEFAULT_KERNEL_SIZE,
	localparam int TAPS       = KERNEL_SIZE * KERNEL_SIZE,
	localparam int DW         = (TAPS > 32) ? 64 : 32,
	localparam int STRIDE     = DW / 8,
	localparam int PAW        = $clog2(3 * STRIDE)
) (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_ready,
	input out_word_t      res_data,
	input logic           psel,
	input logic           penable,
	input logic           pwrite,
	input logic [PAW-1:0] paddr,
	input logic [DW-1:0]  pwdata,
	input logic [DW-1:0]  prdata
);

	logic mask_wr;
	logic mask_rd;

	assign mask_wr = psel && penable && pwrite && (paddr[PAW-1 -: REG_IDX_W] == REG_MASK);
	assign mask_rd = psel && !pwrite && (paddr[PAW-1 -: REG_IDX_W] == REG_MASK);

	// stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result word changed under stall");

	// no result word straight out of reset
	a_reset_quiet: assert property (@(posedge clk)
		$past(!arst_n) |-> !res_valid)
		else $error("result valid right after reset");

	// frame end only on a row end
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.frame_end |-> res_data.row_end)
		else $error("frame_end without row_end");

	// mask reads back the written taps
	a_mask_rb: assert property (@(posedge clk) disable iff (!arst_n)
		mask_wr |=> (!mask_rd || prdata == DW'($past(pwdata[TAPS-1:0]))))
		else $error("kernel mask readback mismatch");

endmodule

bind rgb_morphological_dilation_core rgbmd_checker #(
	.KERNEL_SIZE (KERNEL_SIZE)
) u_rgbmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
